// ===== hdl/cfsp_pkg.sv =====
// cfsp_pkg: shared types, constants and status codes of the serial frame parser
// no dependencies; imported by cfsp_crc, the top level and the checker
`default_nettype none

package cfsp_pkg;

    // payload store depth and derived widths
    localparam int MAX_PAYLOAD = 32;
    localparam int PTR_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CNT_W       = 9;
    localparam int CMP_W       = CNT_W + 1;
    localparam int COUNT_MAX   = (1 << CNT_W) - 1;

    // frame layout
    localparam logic [7:0]  START_MARK  = 8'hAA;
    localparam int          HEAD_BYTES  = 4;
    localparam int          CHECK_BYTES = 2;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] POLY_RESET  = 16'hA001;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_BAD_START = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_CRC_ERROR = 3'd4;

    // result kinds
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [2:0] status;
        logic [7:0] dest_address;
        logic [7:0] src_address;
        logic [7:0] payload_length;
        logic [7:0] payload_byte;
        logic       run_last;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/cfsp_ram.sv =====
// cfsp_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module cfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/cfsp_crc.sv =====
// cfsp_crc: one-byte update of a reflected crc-16 with a programmable polynomial
// depends on cfsp_pkg
`default_nettype none

module cfsp_crc
    import cfsp_pkg::*;
(
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_data,
    input  wire logic [15:0] i_poly,
    output logic      [15:0] o_crc
);

    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {8'h00, i_data};
        // eight bit steps, lsb first
        for (int k = 0; k < 8; k++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ i_poly;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

`default_nettype wire

// ===== hdl/crc16_serial_frame_parser_unit.sv =====
// crc16_serial_frame_parser_unit: top level of the serial frame parser
// depends on cfsp_pkg, cfsp_crc and cfsp_ram
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | in        | i_in_valid / o_in_ready | i_in_item  (t_in_item)
//  out     | out       | o_out_valid/i_out_ready | o_out_item (t_out_item)
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_data (crc polynomial)
//
//  one byte transfer per cycle while a frame is received; the crc byte update
//  is a combinational eight-step unit, so the input side never stalls mid-frame
//  the byte marked end_of_buffer leads to the evaluation state, which loads the
//  status result; each payload byte then needs S_READ and S_LOAD (registered read)
//  synchronous active-low reset; the payload store is not cleared, a frame only
//  reads back entries it wrote itself
//  a stalled output holds its result; the input side is taken again once the
//  last result of the frame sits in the output register
`default_nettype none

module crc16_serial_frame_parser_unit
    import cfsp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // byte input
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    // result output
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item,
    // polynomial register write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    // control states
    localparam logic [1:0] S_RX   = 2'd0;  // taking bytes
    localparam logic [1:0] S_EVAL = 2'd1;  // status decision
    localparam logic [1:0] S_READ = 2'd2;  // payload address to store
    localparam logic [1:0] S_LOAD = 2'd3;  // payload data to output register

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic             r_start_ok, n_start_ok;
    logic [7:0]       r_dest, n_dest;
    logic [7:0]       r_src, n_src;
    logic [7:0]       r_hlen, n_hlen;
    logic [15:0]      r_rx_crc, n_rx_crc;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_rd_end, n_rd_end;
    logic [15:0]      r_poly;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic [15:0]      crc_next;
    logic             in_fire;
    logic             out_free;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] plen_ext;
    logic [CNT_W-1:0] pos;
    logic             ram_we;
    logic [7:0]       ram_rd_data;
    logic [2:0]       eval_status;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign idx_ext  = {1'b0, r_count};
    assign plen_ext = {{(CMP_W-8){1'b0}}, r_hlen};
    assign pos      = r_count - CNT_W'(HEAD_BYTES);

    cfsp_crc u_crc (
        .i_crc  (r_crc),
        .i_data (i_in_item.rx_byte),
        .i_poly (r_poly),
        .o_crc  (crc_next)
    );

    // payload store, written at the byte position, read by the drain pointer
    cfsp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (pos[PTR_W-1:0]),
        .i_wr_data (i_in_item.rx_byte),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (ram_rd_data)
    );

    // status in checking order
    always_comb begin
        priority if (r_count < CNT_W'(HEAD_BYTES + CHECK_BYTES)) begin
            eval_status = ST_TOO_SHORT;
        end else if (!r_start_ok) begin
            eval_status = ST_BAD_START;
        end else if (idx_ext < CMP_W'(HEAD_BYTES + CHECK_BYTES) + plen_ext) begin
            eval_status = ST_TOO_SHORT;
        end else if (r_hlen > 8'(MAX_PAYLOAD)) begin
            eval_status = ST_TOO_LONG;
        end else if (r_rx_crc != r_crc) begin
            eval_status = ST_CRC_ERROR;
        end else begin
            eval_status = ST_OK;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_crc       = r_crc;
        n_start_ok  = r_start_ok;
        n_dest      = r_dest;
        n_src       = r_src;
        n_hlen      = r_hlen;
        n_rx_crc    = r_rx_crc;
        n_rd_ptr    = r_rd_ptr;
        n_rd_end    = r_rd_end;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_we      = 1'b0;

        unique case (r_state)
            S_RX: begin
                if (in_fire) begin
                    if (r_count == '0) begin
                        n_start_ok = (i_in_item.rx_byte == START_MARK);
                    end else if (r_count < CNT_W'(HEAD_BYTES)) begin
                        // header bytes enter the crc
                        if (r_count == CNT_W'(1)) begin
                            n_dest = i_in_item.rx_byte;
                        end else if (r_count == CNT_W'(2)) begin
                            n_src = i_in_item.rx_byte;
                        end else begin
                            n_hlen = i_in_item.rx_byte;
                        end
                        n_crc = crc_next;
                    end else if (idx_ext < CMP_W'(HEAD_BYTES) + plen_ext) begin
                        // payload byte, stored while it fits
                        ram_we = (r_count < CNT_W'(HEAD_BYTES + MAX_PAYLOAD));
                        n_crc  = crc_next;
                    end else if (idx_ext == CMP_W'(HEAD_BYTES) + plen_ext) begin
                        n_rx_crc[15:8] = i_in_item.rx_byte;
                    end else if (idx_ext == CMP_W'(HEAD_BYTES + 1) + plen_ext) begin
                        n_rx_crc[7:0] = i_in_item.rx_byte;
                    end
                    // saturating byte counter
                    if (r_count != CNT_W'(COUNT_MAX)) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_in_item.end_of_buffer) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.kind           = KIND_STATUS;
                    n_out.status         = eval_status;
                    n_out.payload_byte   = 8'h00;
                    if (eval_status == ST_OK) begin
                        n_out.dest_address   = r_dest;
                        n_out.src_address    = r_src;
                        n_out.payload_length = r_hlen;
                        n_out.run_last       = (r_hlen == 8'h00);
                    end else begin
                        n_out.dest_address   = 8'h00;
                        n_out.src_address    = 8'h00;
                        n_out.payload_length = 8'h00;
                        n_out.run_last       = 1'b1;
                    end
                    // drain setup; ok implies the length fits the store
                    n_rd_ptr = '0;
                    n_rd_end = PTR_W'(r_hlen - 8'd1);
                    if (eval_status == ST_OK && r_hlen != 8'h00) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_RX;
                    end
                    // frame state back to reset values
                    n_count    = '0;
                    n_crc      = CRC_INIT;
                    n_start_ok = 1'b0;
                    n_dest     = 8'h00;
                    n_src      = 8'h00;
                    n_hlen     = 8'h00;
                    n_rx_crc   = 16'h0000;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // read address is held, so the store output stays valid under stall
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.kind           = KIND_PAYLOAD;
                    n_out.status         = ST_OK;
                    n_out.dest_address   = 8'h00;
                    n_out.src_address    = 8'h00;
                    n_out.payload_length = 8'h00;
                    n_out.payload_byte   = ram_rd_data;
                    n_out.run_last       = (r_rd_ptr == r_rd_end);
                    if (r_rd_ptr == r_rd_end) begin
                        n_state = S_RX;
                    end else begin
                        n_rd_ptr = r_rd_ptr + PTR_W'(1);
                        n_state  = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_RX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RX;
            r_count     <= '0;
            r_crc       <= CRC_INIT;
            r_start_ok  <= 1'b0;
            r_dest      <= 8'h00;
            r_src       <= 8'h00;
            r_hlen      <= 8'h00;
            r_rx_crc    <= 16'h0000;
            r_rd_ptr    <= '0;
            r_rd_end    <= '0;
            r_out_valid <= 1'b0;
            r_poly      <= POLY_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_start_ok  <= n_start_ok;
            r_dest      <= n_dest;
            r_src       <= n_src;
            r_hlen      <= n_hlen;
            r_rx_crc    <= n_rx_crc;
            r_rd_ptr    <= n_rd_ptr;
            r_rd_end    <= n_rd_end;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_poly <= i_cfg_data;
            end
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_in_ready  = (r_state == S_RX);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== hdl/cfsp_checker.sv =====
// cfsp_checker: port-level assertions of the serial frame parser, bound to the top
// depends on cfsp_pkg and crc16_serial_frame_parser_unit
`default_nettype none

module cfsp_checker
    import cfsp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire t_in_item    i_in_item,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire t_out_item   o_out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // the byte closing a buffer stops byte intake for the evaluation
    a_eval_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.end_of_buffer |=> !o_in_ready)
        else $error("byte intake right after end of buffer");

    // payload results carry no status or header
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_PAYLOAD |->
            o_out_item.status == ST_OK && o_out_item.dest_address == 8'h00 &&
            o_out_item.src_address == 8'h00 && o_out_item.payload_length == 8'h00)
        else $error("payload result with header or status");

    // a failed frame ends in its status result
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_STATUS && o_out_item.status != ST_OK |->
            o_out_item.run_last && o_out_item.payload_byte == 8'h00)
        else $error("failed status result not closing the run");

    // nothing offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind crc16_serial_frame_parser_unit cfsp_checker u_cfsp_checker (.*);

`default_nettype wire
